// File: hw/rtl/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define AST_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/stt_pkg.sv
package stt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_DEL  = 3'd2;
    localparam logic [2:0] OP_STOP = 3'd3;
    localparam logic [2:0] OP_STRT = 3'd4;
    localparam logic [2:0] OP_NEWI = 3'd5;

    localparam logic [1:0] K_ADD  = 2'd0;
    localparam logic [1:0] K_EXP  = 2'd1;
    localparam logic [1:0] K_DONE = 2'd2;

    typedef struct packed {
        logic        used;
        logic        en;
        logic [15:0] cb;
        logic [7:0]  pri;
        logic [31:0] rel;
        logic [31:0] cnt;
    } t_slot;

    typedef struct packed {
        logic [2:0]  op;
        logic        match;
        logic        take;
        logic        run;
        logic [15:0] cb;
        logic [7:0]  pri;
        logic [31:0] ival;
    } t_hctl;

endpackage

// File: hw/rtl/stt_cell.sv
module stt_cell import stt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_d,
    output t_slot o_q
);

    t_slot r_slot;

    // Take the neighbor's word on every shift; clear the slot on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_d;
        end
    end

    assign o_q = r_slot;

endmodule

// File: hw/rtl/stt_head.sv
module stt_head import stt_pkg::*; (
    input  t_slot i_slot,
    input  t_hctl i_ctl,
    output t_slot o_slot,
    output logic  o_fire
);

    always_comb begin
        o_slot = i_slot;
        o_fire = 1'b0;
        case (i_ctl.op)
            OP_TICK: begin
                if (i_ctl.run && i_slot.used && i_slot.en) begin
                    if (i_slot.cnt > 32'd1) begin
                        o_slot.cnt = i_slot.cnt - 32'd1;
                    end else begin
                        o_slot.cnt = i_slot.rel;
                        o_fire     = 1'b1;
                    end
                end
            end
            OP_ADD: begin
                if (i_ctl.take) begin
                    o_slot.used = 1'b1;
                    o_slot.en   = 1'b1;
                    o_slot.cb   = i_ctl.cb;
                    o_slot.pri  = i_ctl.pri;
                    o_slot.rel  = i_ctl.ival;
                    o_slot.cnt  = i_ctl.ival;
                end
            end
            OP_DEL: begin
                if (i_ctl.match) begin
                    o_slot = '0;
                end
            end
            OP_STOP: begin
                if (i_ctl.match) begin
                    o_slot.en = 1'b0;
                end
            end
            OP_STRT: begin
                if (i_ctl.match && i_slot.used && !i_slot.en) begin
                    o_slot.en  = 1'b1;
                    o_slot.cnt = i_slot.rel;
                end
            end
            OP_NEWI: begin
                if (i_ctl.match) begin
                    o_slot.rel = i_ctl.ival;
                    o_slot.cnt = i_ctl.ival;
                    if (i_slot.used) begin
                        o_slot.en = 1'b1;
                    end
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

// File: hw/rtl/software_timer_table_top.sv
// Channel   Handshake            Words
// command   start / busy         i_op i_handle i_callback_id i_priority_req i_interval_ms
// result    o_strobe (no stall)  o_kind o_slot o_fired_callback o_fired_priority
//                                o_to_queue o_add_ok o_live_count o_running
//                                o_table_full o_last
//
// Every command is accepted, then the ring of slot cells rotates once past the
// head unit, slot by slot, and then the command closes.
// Each expiry word comes out in the cycle after its slot passes the head; the final
// word is registered from the closing state and comes out with busy already low.
// Reset is synchronous, active low; it clears the slot marks, count and running flag.
// The receiver cannot stall: each result word is on the ports for one cycle only.
module software_timer_table_top import stt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_handle,
    input  logic [15:0] i_callback_id,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_interval_ms,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic [15:0] o_fired_callback,
    output logic [7:0]  o_fired_priority,
    output logic        o_to_queue,
    output logic        o_add_ok,
    output logic [4:0]  o_live_count,
    output logic        o_running,
    output logic        o_table_full,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_aslot, n_aslot;
    logic               r_found, n_found;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_run, n_run;

    // Command word held for the whole rotation.
    logic [2:0]         r_op;
    logic [3:0]         r_handle;
    logic [15:0]        r_cb;
    logic [7:0]         r_pri;
    logic [31:0]        r_ival;

    // Result word registers.
    logic               r_stb, n_stb;
    logic [1:0]         r_kind, n_kind;
    logic [3:0]         r_slot, n_slot;
    logic [15:0]        r_fcb, n_fcb;
    logic [7:0]         r_fpri, n_fpri;
    logic               r_q, n_q;
    logic               r_ok, n_ok;
    logic [4:0]         r_live, n_live;
    logic               r_orun, n_orun;
    logic               r_full, n_full;
    logic               r_last, n_last;

    t_slot              cell_q [NUM_SLOTS];
    t_slot              head_out;
    t_hctl              hctl;
    logic               fire;
    logic               shift;
    logic               hok;

    assign shift = (r_state == S_WALK);
    assign hok   = ({1'b0, r_handle} < 5'(NUM_SLOTS));

    // Ring of slot cells: each shifts toward cell 0; cell 0 feeds the head,
    // whose updated word goes back in at the far end.
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_ring
        t_slot d;
        if (k == NUM_SLOTS - 1) begin : g_tail
            assign d = head_out;
        end else begin : g_mid
            assign d = cell_q[k+1];
        end
        stt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_d     (d),
            .o_q     (cell_q[k])
        );
    end

    always_comb begin
        hctl.op    = r_op;
        hctl.match = hok && (r_handle[IDX_W-1:0] == r_idx);
        hctl.take  = !r_found && !cell_q[0].used;
        hctl.run   = r_run;
        hctl.cb    = r_cb;
        hctl.pri   = r_pri;
        hctl.ival  = r_ival;
    end

    stt_head u_head (
        .i_slot (cell_q[0]),
        .i_ctl  (hctl),
        .o_slot (head_out),
        .o_fire (fire)
    );

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_aslot = r_aslot;
        n_found = r_found;
        n_count = r_count;
        n_run   = r_run;
        n_stb   = 1'b0;
        n_kind  = K_DONE;
        n_slot  = '0;
        n_fcb   = '0;
        n_fpri  = '0;
        n_q     = 1'b0;
        n_ok    = 1'b0;
        n_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_WALK;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_aslot = '0;
                end
            end
            S_WALK: begin
                // Emit expiries in slot order as they pass the head.
                if (fire) begin
                    n_stb  = 1'b1;
                    n_kind = K_EXP;
                    n_slot = 4'(r_idx);
                    n_fcb  = cell_q[0].cb;
                    n_fpri = cell_q[0].pri;
                    n_q    = (cell_q[0].pri != 8'd0);
                end
                if (r_op == OP_ADD && hctl.take) begin
                    n_found = 1'b1;
                    n_aslot = r_idx;
                    n_count = r_count + CNT_W'(1);
                    n_run   = 1'b1;
                end
                if (r_op == OP_DEL && hctl.match && cell_q[0].used && r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
                if (r_idx == IDX_W'(NUM_SLOTS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FIN: begin
                if (r_op == OP_DEL && hok && r_count == '0) begin
                    n_run = 1'b0;
                end
                n_stb  = 1'b1;
                n_last = 1'b1;
                if (r_op == OP_ADD) begin
                    n_kind = K_ADD;
                    n_ok   = r_found;
                    n_slot = r_found ? 4'(r_aslot) : 4'd0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_live = 5'(n_count);
        n_orun = n_run;
        n_full = (n_count == CNT_W'(NUM_SLOTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_run   <= 1'b0;
            r_stb   <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_run   <= n_run;
            r_stb   <= n_stb;
            r_found <= n_found;
            r_idx   <= n_idx;
        end
    end

    // Latch the command word on accept; register the result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op     <= i_op;
            r_handle <= i_handle;
            r_cb     <= i_callback_id;
            r_pri    <= i_priority_req;
            r_ival   <= i_interval_ms;
        end
        r_aslot <= n_aslot;
        r_kind  <= n_kind;
        r_slot  <= n_slot;
        r_fcb   <= n_fcb;
        r_fpri  <= n_fpri;
        r_q     <= n_q;
        r_ok    <= n_ok;
        r_live  <= n_live;
        r_orun  <= n_orun;
        r_full  <= n_full;
        r_last  <= n_last;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_stb;
    assign o_kind           = r_kind;
    assign o_slot           = r_slot;
    assign o_fired_callback = r_fcb;
    assign o_fired_priority = r_fpri;
    assign o_to_queue       = r_q;
    assign o_add_ok         = r_ok;
    assign o_live_count     = r_live;
    assign o_running        = r_orun;
    assign o_table_full     = r_full;
    assign o_last           = r_last;

endmodule

// File: hw/rtl/stt_check.sv
`include "assert_macros.svh"
module stt_check import stt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_kind,
    input logic [3:0]  o_slot,
    input logic        o_add_ok,
    input logic [4:0]  o_live_count,
    input logic        o_table_full,
    input logic        o_last
);

    `AST_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `AST_NOW(a_exp_not_last, i_clk, i_rst_n, o_strobe && o_kind == K_EXP, !o_last)
    `AST_NOW(a_full_count, i_clk, i_rst_n, o_strobe,
        o_table_full == (o_live_count == 5'(NUM_SLOTS)))
    `AST_NOW(a_add_fail_slot, i_clk, i_rst_n, o_strobe && o_kind == K_ADD && !o_add_ok,
        o_slot == 4'd0)
    `AST_NEXT(a_last_idle, i_clk, i_rst_n, o_strobe && o_last, !o_strobe)

endmodule

bind software_timer_table_top stt_check u_stt_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_kind       (o_kind),
    .o_slot       (o_slot),
    .o_add_ok     (o_add_ok),
    .o_live_count (o_live_count),
    .o_table_full (o_table_full),
    .o_last       (o_last)
);

// File: tb/software_timer_table_top_test.sv
`timescale 1ns / 1ps

module software_timer_table_top_test;
    import stt_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [15:0] fired_callback;
        logic [7:0]  fired_priority;
        logic        to_queue;
        logic        add_ok;
        logic [4:0]  live_count;
        logic        running;
        logic        table_full;
        logic        last;
    } t_word;

    // Predicts the result words of the timer table and checks the ones that come out.
    class timer_scoreboard;
        bit          used[NUM_SLOTS];
        bit          en[NUM_SLOTS];
        logic [15:0] cb[NUM_SLOTS];
        logic [7:0]  pri[NUM_SLOTS];
        logic [31:0] rel[NUM_SLOTS];
        logic [31:0] cnt[NUM_SLOTS];
        int          live;
        bit          run;
        t_word       pending[$];
        int          errors;

        function void clear();
            foreach (used[i]) begin
                used[i] = 0; en[i] = 0; cb[i] = 0; pri[i] = 0; rel[i] = 0; cnt[i] = 0;
            end
            live = 0;
            run = 0;
            pending.delete();
            errors = 0;
        endfunction

        function bit full();
            foreach (used[i]) if (!used[i]) return 0;
            return 1;
        endfunction

        function void push(logic [1:0] k, int s, logic [15:0] c, logic [7:0] p,
                           bit q, bit ok, bit lst);
            t_word w;
            w.kind = k; w.slot = s[3:0]; w.fired_callback = c; w.fired_priority = p;
            w.to_queue = q; w.add_ok = ok; w.live_count = live[4:0]; w.running = run;
            w.table_full = full(); w.last = lst;
            pending.push_back(w);
        endfunction

        function void arm(int h);
            if (!used[h] || en[h]) return;
            cnt[h] = rel[h];
            en[h] = 1;
        endfunction

        // Note an accepted command word: advance the table and queue its results.
        function void note_command(logic [2:0] op, logic [3:0] h, logic [15:0] c,
                                   logic [7:0] p, logic [31:0] iv);
            case (op)
                OP_TICK: if (run) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!used[i] || !en[i]) continue;
                        if (cnt[i] > 1) begin
                            cnt[i]--;
                            continue;
                        end
                        cnt[i] = rel[i];
                        push(K_EXP, i, cb[i], pri[i], pri[i] != 0, 0, 0);
                    end
                end
                OP_ADD: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!used[i]) begin
                            used[i] = 1; cb[i] = c; pri[i] = p; rel[i] = iv; cnt[i] = iv;
                            en[i] = 1; live++; run = 1;
                            push(K_ADD, i, 0, 0, 0, 1, 1);
                            return;
                        end
                    end
                    push(K_ADD, 0, 0, 0, 0, 0, 1);
                    return;
                end
                OP_DEL: begin
                    if (used[h] && live > 0) live--;
                    used[h] = 0; en[h] = 0; cb[h] = 0; pri[h] = 0; rel[h] = 0; cnt[h] = 0;
                    if (live == 0) run = 0;
                end
                OP_STOP: en[h] = 0;
                OP_STRT: arm(h);
                OP_NEWI: begin
                    rel[h] = iv;
                    cnt[h] = iv;
                    arm(h);
                end
                default: ;
            endcase
            push(K_DONE, 0, 0, 0, 0, 0, 1);
        endfunction

        function void check_word(t_word a);
            t_word e;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind) begin
                $error("kind exp %0d got %0d", e.kind, a.kind); errors++;
            end
            if (a.slot !== e.slot) begin
                $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
            end
            if (a.fired_callback !== e.fired_callback) begin
                $error("fired_callback exp %0h got %0h", e.fired_callback, a.fired_callback);
                errors++;
            end
            if (a.fired_priority !== e.fired_priority) begin
                $error("fired_priority exp %0h got %0h", e.fired_priority, a.fired_priority);
                errors++;
            end
            if (a.to_queue !== e.to_queue) begin
                $error("to_queue exp %0b got %0b", e.to_queue, a.to_queue); errors++;
            end
            if (a.add_ok !== e.add_ok) begin
                $error("add_ok exp %0b got %0b", e.add_ok, a.add_ok); errors++;
            end
            if (a.live_count !== e.live_count) begin
                $error("live_count exp %0d got %0d", e.live_count, a.live_count); errors++;
            end
            if (a.running !== e.running) begin
                $error("running exp %0b got %0b", e.running, a.running); errors++;
            end
            if (a.table_full !== e.table_full) begin
                $error("table_full exp %0b got %0b", e.table_full, a.table_full); errors++;
            end
            if (a.last !== e.last) begin
                $error("last exp %0b got %0b", e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  i_op = '0;
    logic [3:0]  i_handle = '0;
    logic [15:0] i_callback_id = '0;
    logic [7:0]  i_priority_req = '0;
    logic [31:0] i_interval_ms = '0;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [3:0]  o_slot;
    logic [15:0] o_fired_callback;
    logic [7:0]  o_fired_priority;
    logic        o_to_queue;
    logic        o_add_ok;
    logic [4:0]  o_live_count;
    logic        o_running;
    logic        o_table_full;
    logic        o_last;

    timer_scoreboard sb;
    bit quiet;  // suppress idle gaps in the no-idle stretch

    software_timer_table_top uut (.*);

    always #6 i_clk = ~i_clk;

    // Sample result words at the rising edge; the receiver never stalls.
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_strobe) begin
            w.kind = o_kind; w.slot = o_slot; w.fired_callback = o_fired_callback;
            w.fired_priority = o_fired_priority; w.to_queue = o_to_queue;
            w.add_ok = o_add_ok; w.live_count = o_live_count; w.running = o_running;
            w.table_full = o_table_full; w.last = o_last;
            sb.check_word(w);
        end
    end

    // Drive one command word; hold it until accepted, then sometimes drop start for a while.
    task automatic send(logic [2:0] op, logic [3:0] h, logic [15:0] c,
                        logic [7:0] p, logic [31:0] iv);
        i_op <= op; i_handle <= h; i_callback_id <= c;
        i_priority_req <= p; i_interval_ms <= iv;
        start <= 1;
        do @(posedge i_clk); while (busy);
        sb.note_command(op, h, c, p, iv);
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 23) begin
            start <= 0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // Random interval: mostly short so timers fire, sometimes edge values.
    function automatic logic [31:0] pick_interval();
        case ($urandom_range(9))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(6);
        endcase
    endfunction

    // Handles aimed at live slots so ops mostly take effect.
    function automatic logic [3:0] pick_handle();
        int live[$];
        foreach (sb.used[i]) if (sb.used[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(3) != 0)
            return 4'(live[$urandom_range(live.size() - 1)]);
        return 4'($urandom_range(15));
    endfunction

    initial begin
        #2_000_000;
        $display("FAIL software_timer_table_top");
        $finish;
    end

    initial begin
        logic [2:0] op;
        sb = new();
        sb.clear();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: tick while stopped, delete of a free slot, ops on an empty table.
        send(OP_TICK, 0, 0, 0, 0);
        send(OP_DEL, 4'd15, 0, 0, 0);
        send(OP_STRT, 4'd3, 0, 0, 0);
        send(OP_NEWI, 4'd2, 0, 0, 32'h5);
        send(3'd6, 4'd0, 0, 0, 0);
        send(3'd7, 4'd15, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        // Fill the table with extreme fields, then overflow it.
        for (int i = 0; i < NUM_SLOTS; i++)
            send(OP_ADD, 0, (i & 1) ? 16'hFFFF : 16'h0, (i & 2) ? 8'hFF : 8'h0,
                 (i < 2) ? i : ((i == 15) ? 32'hFFFF_FFFF : 32'd2));
        send(OP_ADD, 0, 16'h1234, 8'h1, 32'd1);
        send(OP_TICK, 0, 0, 0, 0);
        send(OP_STOP, 4'd0, 0, 0, 0);
        send(OP_STRT, 4'd1, 0, 0, 0);
        send(OP_NEWI, 4'd0, 0, 0, 32'd1);
        send(OP_TICK, 0, 0, 0, 0);
        drain();

        // Empty the table so running drops.
        for (int i = 0; i < NUM_SLOTS; i++) send(OP_DEL, 4'(i), 0, 0, 0);
        send(OP_TICK, 0, 0, 0, 0);

        // Random: ticks dominate so the timers fire; a quiet stretch without idling.
        for (int n = 0; n < 105; n++) begin
            quiet = (n >= 60 && n < 90);
            case ($urandom_range(19))
                0, 1, 2, 3:  op = OP_ADD;
                4, 5:        op = OP_DEL;
                6:           op = OP_STOP;
                7:           op = OP_STRT;
                8:           op = OP_NEWI;
                9:           op = 3'($urandom_range(7));
                default:     op = OP_TICK;
            endcase
            send(op, pick_handle(), 16'($urandom),
                 $urandom_range(1) ? 8'($urandom) : 8'h0, pick_interval());
            if (n == 100) drain();
        end
        drain();
        repeat (40) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS software_timer_table_top");
        else
            $display("FAIL software_timer_table_top");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_cell.sv
hw/rtl/stt_head.sv
hw/rtl/software_timer_table_top.sv
hw/rtl/stt_check.sv
tb/software_timer_table_top_test.sv
